[rtl/ihp_pkg.sv]
// Shared constants, codes, types and helpers of the indexed min-heap.
package ihp_pkg;

    localparam int CAPACITY  = 256;
    localparam int ID_COUNT  = 256;
    localparam int KEY_WIDTH = 32;

    localparam int ID_W   = $clog2(ID_COUNT);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int SLOT_W = ADDR_W + 1;     // slot numbers 1..CAPACITY, also the count
    localparam int KIND_W = 2;
    localparam int ERR_W  = 3;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELMIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_FULL    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DUP     = 3'd4;

    typedef struct packed {
        logic        [ID_W-1:0]      id;
        logic signed [KEY_WIDTH-1:0] key;
    } t_entry;

    typedef struct packed {
        logic pick_b;   // second candidate strictly smaller than first
        logic lt;       // chosen candidate strictly below the moving key
        logic gt;       // chosen candidate strictly above the moving key
    } t_cmp;

    // slot number (1-based) to memory address
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] t;
        t = s - SLOT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

[rtl/ihp_cmp.sv]
// Shared key comparator: picks the smaller of two candidates, compares it to the moving key.
module ihp_cmp (
    input  ihp_pkg::t_entry                       i_cand_a,
    input  ihp_pkg::t_entry                       i_cand_b,
    input  logic                                  i_b_valid,
    input  logic signed [ihp_pkg::KEY_WIDTH-1:0]  i_cur_key,
    output ihp_pkg::t_entry                       o_pick,
    output ihp_pkg::t_cmp                         o_cmp
);

    logic b_less;

    // left candidate wins a tie
    assign b_less        = i_b_valid && (i_cand_b.key < i_cand_a.key);
    assign o_pick        = b_less ? i_cand_b : i_cand_a;
    assign o_cmp.pick_b  = b_less;
    assign o_cmp.lt      = o_pick.key < i_cur_key;
    assign o_cmp.gt      = o_pick.key > i_cur_key;

endmodule

[rtl/indexed_min_heap.sv]
// Indexed binary min-heap of (id, key) entries: sequencer, heap and position memories.
//
// Each input beat is one operation: insert (id, key), delete the minimum, or update the
// key of a present id. Every operation yields exactly one output beat with the root id
// and key after the operation (zero when empty), the entry count, an empty flag and an
// error code; a rejected operation leaves the heap untouched. Keys are signed Q16.16 and
// smaller keys come out first; on equal children the left one is taken. One operation is
// in work at a time and o_in_ready is low meanwhile. A rejected or no-op beat goes straight
// to the result; an insert climbs from the new last slot level by level; delete-min ends
// at once when it removes the last entry, else sifts the last entry down from the root;
// update sifts down and, if it did not move, up. Each level of a sift, through the single
// heap memory, is a registered read (two ports, so both children of a node come back
// together) followed by a compare-and-write step through the one shared comparator. The
// moving entry is carried in a register (hole-style sift), so each level costs one write
// instead of a swap. The next input beat may be accepted while the previous result still
// sits unread in the output register, but not while a finished result waits to enter it.
// The id-to-slot table is a memory with a flip-flop valid bit per id; reset clears the
// valid bits at once, so there is no clearing pass.
module indexed_min_heap (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ihp_pkg::KIND_W-1:0]            i_kind,
    input  logic [ihp_pkg::ID_W-1:0]              i_entry_id,
    input  logic signed [ihp_pkg::KEY_WIDTH-1:0]  i_entry_key,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ihp_pkg::ID_W-1:0]              o_min_id,
    output logic signed [ihp_pkg::KEY_WIDTH-1:0]  o_min_key,
    output logic [ihp_pkg::SLOT_W-1:0]            o_entry_count,
    output logic                                  o_is_empty,
    output logic [ihp_pkg::ERR_W-1:0]             o_error_code
);

    localparam int SLOT_W = ihp_pkg::SLOT_W;
    localparam int ADDR_W = ihp_pkg::ADDR_W;
    localparam int ID_W   = ihp_pkg::ID_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEL_WAIT = 4'd1;   // last entry coming back from memory
    localparam logic [3:0] S_UPD_WAIT = 4'd2;   // slot of the id coming back
    localparam logic [3:0] S_UP_RD    = 4'd3;   // read parent
    localparam logic [3:0] S_UP_CMP   = 4'd4;   // compare with parent, move it down
    localparam logic [3:0] S_DN_RD    = 4'd5;   // read both children
    localparam logic [3:0] S_DN_CMP   = 4'd6;   // compare smaller child, move it up
    localparam logic [3:0] S_PLACE    = 4'd7;   // drop the moving entry into its slot
    localparam logic [3:0] S_FIN      = 4'd8;   // hand result to output register

    // memories
    ihp_pkg::t_entry   r_heap [ihp_pkg::CAPACITY];
    logic [SLOT_W-1:0] r_pos  [ihp_pkg::ID_COUNT];
    logic [ihp_pkg::ID_COUNT-1:0] r_pos_vld;

    ihp_pkg::t_entry   r_rd_a, r_rd_b;
    logic [SLOT_W-1:0] r_pos_rd;

    // control and datapath registers
    logic [3:0]                   r_state, n_state;
    ihp_pkg::t_entry              r_cur, n_cur;        // entry being sifted
    logic [SLOT_W-1:0]            r_p, n_p;            // its current hole
    logic [SLOT_W-1:0]            r_c, n_c;            // left child slot
    logic                         r_bvld, n_bvld;      // right child exists
    logic                         r_moved, n_moved;    // sift-down moved at least once
    logic [ihp_pkg::ERR_W-1:0]    r_err, n_err;
    logic [SLOT_W-1:0]            r_count, n_count;
    ihp_pkg::t_entry              r_root;              // copy of slot 1

    logic                         r_out_vld, n_out_vld;
    logic [ID_W-1:0]              r_o_id;
    logic signed [ihp_pkg::KEY_WIDTH-1:0] r_o_key;
    logic [SLOT_W-1:0]            r_o_cnt;
    logic                         r_o_empty;
    logic [ihp_pkg::ERR_W-1:0]    r_o_err;
    logic                         out_load;

    // memory ports
    logic [ADDR_W-1:0]  hp_ra, hp_rb, hp_wa;
    logic               hp_we;
    ihp_pkg::t_entry    hp_wd;
    logic               ps_we;
    logic [ID_W-1:0]    ps_wa;
    logic [SLOT_W-1:0]  ps_wd;
    logic               vld_clr;

    // compare unit
    ihp_pkg::t_entry    pick;
    ihp_pkg::t_cmp      cmp;
    logic               cmp_bvld;
    logic [SLOT_W:0]    c_slot;
    logic [SLOT_W-1:0]  pick_slot;
    logic               in_acc;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cmp_bvld = (r_state == S_DN_CMP) && r_bvld;
    assign c_slot   = {r_p, 1'b0};
    assign pick_slot = r_c + SLOT_W'(cmp.pick_b);

    ihp_cmp u_cmp (
        .i_cand_a  (r_rd_a),
        .i_cand_b  (r_rd_b),
        .i_b_valid (cmp_bvld),
        .i_cur_key (r_cur.key),
        .o_pick    (pick),
        .o_cmp     (cmp)
    );

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_p       = r_p;
        n_c       = r_c;
        n_bvld    = r_bvld;
        n_moved   = r_moved;
        n_err     = r_err;
        n_count   = r_count;
        hp_ra     = '0;
        hp_rb     = '0;
        hp_we     = 1'b0;
        hp_wa     = ihp_pkg::slot_addr(r_p);
        hp_wd     = r_cur;
        ps_we     = 1'b0;
        ps_wa     = r_cur.id;
        ps_wd     = r_p;
        vld_clr   = 1'b0;
        out_load  = 1'b0;
        n_out_vld = r_out_vld && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur   = '{id: i_entry_id, key: i_entry_key};
                    n_moved = 1'b0;
                    n_err   = ihp_pkg::ERR_OK;
                    n_state = S_FIN;
                    unique case (i_kind)
                        ihp_pkg::KIND_INSERT: begin
                            if (r_pos_vld[i_entry_id]) begin
                                n_err = ihp_pkg::ERR_DUP;
                            end else if (r_count == SLOT_W'(ihp_pkg::CAPACITY)) begin
                                n_err = ihp_pkg::ERR_FULL;
                            end else begin
                                n_count = r_count + SLOT_W'(1);
                                n_p     = r_count + SLOT_W'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        ihp_pkg::KIND_DELMIN: begin
                            if (r_count == '0) begin
                                n_err = ihp_pkg::ERR_EMPTY;
                            end else begin
                                vld_clr = 1'b1;
                                hp_ra   = ihp_pkg::slot_addr(r_count);
                                n_count = r_count - SLOT_W'(1);
                                n_p     = SLOT_W'(1);
                                n_state = S_DEL_WAIT;
                            end
                        end
                        ihp_pkg::KIND_UPDATE: begin
                            if (!r_pos_vld[i_entry_id]) begin
                                n_err = ihp_pkg::ERR_UNKNOWN;
                            end else begin
                                n_state = S_UPD_WAIT;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_DEL_WAIT: begin
                n_cur   = r_rd_a;
                n_state = (r_count == '0) ? S_FIN : S_DN_RD;
            end
            S_UPD_WAIT: begin
                n_p     = r_pos_rd;
                n_state = S_DN_RD;
            end
            S_UP_RD: begin
                if (r_p == SLOT_W'(1)) begin
                    n_state = S_PLACE;
                end else begin
                    hp_ra   = ihp_pkg::slot_addr(r_p >> 1);
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (cmp.gt) begin
                    hp_we   = 1'b1;
                    hp_wd   = pick;
                    ps_we   = 1'b1;
                    ps_wa   = pick.id;
                    n_p     = r_p >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_RD: begin
                if (c_slot > {1'b0, r_count}) begin
                    n_state = r_moved ? S_PLACE : S_UP_RD;
                end else begin
                    hp_ra   = ihp_pkg::slot_addr(c_slot[SLOT_W-1:0]);
                    hp_rb   = c_slot[ADDR_W-1:0];
                    n_c     = c_slot[SLOT_W-1:0];
                    n_bvld  = c_slot < {1'b0, r_count};
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (cmp.lt) begin
                    hp_we   = 1'b1;
                    hp_wd   = pick;
                    ps_we   = 1'b1;
                    ps_wa   = pick.id;
                    n_p     = pick_slot;
                    n_moved = 1'b1;
                    n_state = S_DN_RD;
                end else begin
                    n_state = r_moved ? S_PLACE : S_UP_RD;
                end
            end
            S_PLACE: begin
                hp_we   = 1'b1;
                ps_we   = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    out_load  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            r_heap[hp_wa] <= hp_wd;
        end
        r_rd_a <= r_heap[hp_ra];
        r_rd_b <= r_heap[hp_rb];
    end

    // id-to-slot memory
    always_ff @(posedge i_clk) begin
        if (ps_we) begin
            r_pos[ps_wa] <= ps_wd;
        end
        r_pos_rd <= r_pos[i_entry_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_vld <= '0;
        end else begin
            if (vld_clr) begin
                r_pos_vld[r_root.id] <= 1'b0;
            end
            if (ps_we) begin
                r_pos_vld[ps_wa] <= 1'b1;
            end
        end
    end

    // root copy follows every write to slot 1
    always_ff @(posedge i_clk) begin
        if (hp_we && hp_wa == '0) begin
            r_root <= hp_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_moved   <= 1'b0;
            r_err     <= ihp_pkg::ERR_OK;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_moved   <= n_moved;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_p    <= n_p;
        r_c    <= n_c;
        r_bvld <= n_bvld;
        if (out_load) begin
            r_o_id    <= (r_count == '0) ? '0 : r_root.id;
            r_o_key   <= (r_count == '0) ? '0 : r_root.key;
            r_o_cnt   <= r_count;
            r_o_empty <= (r_count == '0);
            r_o_err   <= r_err;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_min_id      = r_o_id;
    assign o_min_key     = r_o_key;
    assign o_entry_count = r_o_cnt;
    assign o_is_empty    = r_o_empty;
    assign o_error_code  = r_o_err;

    // ---- assertions ----
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOT_W'(ihp_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hp_we |-> (r_p != '0 && r_p <= r_count))
        else $error("heap write outside occupied slots");

    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == ihp_pkg::KIND_DELMIN && r_count != '0)
            |=> (r_count == $past(r_count) - SLOT_W'(1)))
        else $error("delete-min did not drop the count by one");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_entry_count == '0 && o_min_id == '0
            && o_min_key == '0))
        else $error("empty result with nonzero fields");

endmodule
